// ----- hw/rtl/sdta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_pkg: shared types and constants for the signed decimal to ASCII core
// Holds the queue word format, field widths and the ASCII codes used by the
// front, queue and back modules.
// ----------------------------------------------------------------------------
package sdta_pkg;

    // Field and datapath widths.
    localparam int ValueW    = 16;
    localparam int MagW      = 16;
    localparam int NumDigits = 5;
    localparam int BcdW      = 4 * NumDigits;
    localparam int DigitIdxW = 3;
    localparam int StepCntW  = 4;
    localparam int CharW     = 8;

    // Index of the last double-dabble shift step; one step per magnitude bit.
    localparam logic [StepCntW-1:0] LastStep = StepCntW'(MagW - 1);

    // Queue geometry between the front and back parts.
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = 1;
    localparam int QueueCntW  = 2;

    // ASCII codes.
    localparam logic [CharW-1:0] AsciiZero  = 8'd48;
    localparam logic [CharW-1:0] AsciiMinus = 8'd45;

    // One classified word: sign flag and magnitude.
    typedef struct packed {
        logic            neg;
        logic [MagW-1:0] mag;
    } sdta_item_t;

endpackage

// ----- hw/rtl/sdta_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_front: input stage
// Accepts one signed word, splits it into sign and magnitude, and holds it
// until the queue has room.
// ----------------------------------------------------------------------------
module sdta_front
    import sdta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ValueW-1:0] value,
    output logic              push_valid,
    output sdta_item_t        push_item,
    input  logic              queue_full
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    sdta_item_t item_reg;
    sdta_item_t item_next;
    logic       accept;
    logic       push;

    // The holding register stalls the input only while it is full and blocked.
    assign in_stall   = hold_valid_reg && queue_full;
    assign accept     = in_valid && !in_stall;
    assign push       = hold_valid_reg && !queue_full;
    assign push_valid = hold_valid_reg;
    assign push_item  = item_reg;

    // Classify the word: sign bit and two's complement magnitude.
    always_comb
    begin
        item_next.neg = value[ValueW-1];
        if (value[ValueW-1])
        begin
            item_next.mag = MagW'(~value + 1'b1);
        end
        else
        begin
            item_next.mag = MagW'(value);
        end
    end

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hw/rtl/sdta_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_queue: short queue between front and back
// A two-entry first-in first-out buffer of classified words so that the
// front and back parts stall independently.
// ----------------------------------------------------------------------------
module sdta_queue
    import sdta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    input  sdta_item_t push_item,
    output logic       queue_full,
    input  logic       pop,
    output logic       queue_empty,
    output sdta_item_t pop_item
);

    sdta_item_t            entry_reg [QueueDepth];
    logic [QueuePtrW-1:0]  wr_ptr_reg;
    logic [QueuePtrW-1:0]  wr_ptr_next;
    logic [QueuePtrW-1:0]  rd_ptr_reg;
    logic [QueuePtrW-1:0]  rd_ptr_next;
    logic [QueueCntW-1:0]  count_reg;
    logic [QueueCntW-1:0]  count_next;
    logic                  do_push;
    logic                  do_pop;

    assign queue_full  = (count_reg == QueueCntW'(QueueDepth));
    assign queue_empty = (count_reg == '0);
    assign do_push     = push_valid && !queue_full;
    assign do_pop      = pop && !queue_empty;
    assign pop_item    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/sdta_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_back: conversion and character output
// Turns a magnitude into five BCD digits with one double-dabble step per
// cycle, then sends the sign and the significant digits one per word.
// ----------------------------------------------------------------------------
module sdta_back
    import sdta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  sdta_item_t       pop_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CharW-1:0] char_code,
    output logic             last_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [MagW-1:0]       shift_reg;
    logic [MagW-1:0]       shift_next;
    logic [BcdW-1:0]       bcd_reg;
    logic [BcdW-1:0]       bcd_next;
    logic [StepCntW-1:0]   step_reg;
    logic [StepCntW-1:0]   step_next;
    logic [DigitIdxW-1:0]  idx_reg;
    logic [DigitIdxW-1:0]  idx_next;
    logic                  sign_pend_reg;
    logic                  sign_pend_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CharW-1:0]      char_reg;
    logic [CharW-1:0]      char_next;
    logic                  last_reg;
    logic                  last_next;

    logic [BcdW-1:0]       bcd_adj;
    logic [DigitIdxW-1:0]  top_idx;
    logic [3:0]            cur_digit;
    logic                  out_free;

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_IDLE) && !queue_empty;
    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];

    // Add three to every BCD digit of five or more before the shift.
    always_comb
    begin
        for (int d = 0; d < NumDigits; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // Highest nonzero digit; digit zero when the whole value is zero.
    always_comb
    begin
        top_idx = '0;
        for (int d = 1; d < NumDigits; d++)
        begin
            if (bcd_reg[4*d +: 4] != 4'd0)
            begin
                top_idx = DigitIdxW'(d);
            end
        end
    end

    // Sequencer next-state and output logic.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        sign_pend_next = sign_pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    neg_next   = pop_item.neg;
                    shift_next = pop_item.mag;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next   = {bcd_adj[BcdW-2:0], shift_reg[MagW-1]};
                shift_next = {shift_reg[MagW-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == LastStep)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next       = top_idx;
                sign_pend_next = neg_reg;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        char_next      = AsciiMinus;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        char_next = AsciiZero + {4'b0000, cur_digit};
                        last_next = (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            shift_reg     <= '0;
            bcd_reg       <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            shift_reg     <= shift_next;
            bcd_reg       <= bcd_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

endmodule

// ----- hw/rtl/signed_decimal_to_ascii_core.sv -----
`timescale 1ns / 1ps
// The first character of a value passes the input register, the queue,
// 16 double-dabble steps, the digit scan and the output register.
// Values are converted one at a time by the single double-dabble shifter in the
// back part; it takes a new value only after the last character of the one before.
// Reset: asynchronous, active low; the queue and all control state are emptied.
// ----------------------------------------------------------------------------
// signed_decimal_to_ascii_core: signed 16-bit integer to ASCII decimal text
// Front part classifies each word into sign and magnitude, a short queue
// buffers it, and the back part converts it and sends one character per word.
// ----------------------------------------------------------------------------
module signed_decimal_to_ascii_core
    import sdta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ValueW-1:0] value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CharW-1:0]  char_code,
    output logic              last_char
);

    logic       push_valid;
    sdta_item_t push_item;
    logic       queue_full;
    logic       queue_empty;
    logic       pop;
    sdta_item_t pop_item;

    // Input classification.
    sdta_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // Decoupling queue.
    sdta_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .queue_full  (queue_full),
        .pop         (pop),
        .queue_empty (queue_empty),
        .pop_item    (pop_item)
    );

    // Conversion and character output.
    sdta_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .last_char   (last_char)
    );

endmodule

// ----- tb/signed_decimal_to_ascii_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_to_ascii_core_tb: self-checking bench for the decimal core
// Sends signed 16-bit words, directed corner values first and random ones
// after, and predicts the ASCII text of each accepted word. Every character
// word that leaves the core is compared against the oldest predicted one.
// ----------------------------------------------------------------------------
module signed_decimal_to_ascii_core_tb;
    import sdta_pkg::*;

    localparam int Radix         = 10;
    localparam int IdlePct       = 26;
    localparam int RandomItems   = 440;
    localparam int QuietFirst    = 200;
    localparam int QuietLast     = 300;
    localparam int HoldAfter     = 300;
    localparam int HoldCycles    = 400;
    localparam int DrainCycles   = 40;
    localparam int WatchdogLimit = 2000;

    // One character word as it leaves the core.
    typedef struct packed {
        logic [CharW-1:0] code;
        logic             last_flag;
    } char_word_t;

    // Predicts the text of each accepted value and checks the character words.
    class text_scoreboard;
        char_word_t expected_q[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // Work out the characters of one accepted value and queue them.
        function void note_value(logic [ValueW-1:0] v);
            logic [CharW-1:0] digits[NumDigits];
            logic [MagW:0]    mag;
            char_word_t       w;
            int               nd;
            bit               neg;
            neg = v[ValueW-1];
            mag = neg ? ((MagW+1)'(1 << MagW) - {1'b0, v}) : {1'b0, v};
            nd  = 0;
            if (mag == '0)
            begin
                digits[0] = AsciiZero;
                nd = 1;
            end
            else
            begin
                // Least significant digit first; the queue gets them reversed.
                while (mag != '0 && nd < NumDigits)
                begin
                    digits[nd] = AsciiZero + CharW'(mag % Radix);
                    mag = (MagW+1)'(mag / Radix);
                    nd++;
                end
            end
            if (neg)
            begin
                w.code = AsciiMinus;
                w.last_flag = 1'b0;
                expected_q.push_back(w);
            end
            for (int k = nd - 1; k >= 0; k--)
            begin
                w.code = digits[k];
                w.last_flag = (k == 0);
                expected_q.push_back(w);
            end
        endfunction

        // Compare one accepted character word with the oldest prediction.
        function void check_char(logic [CharW-1:0] code, logic last_flag);
            char_word_t w;
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: char_code %0d last_char %0d", code, last_flag);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (code !== w.code)
            begin
                $error("char_code mismatch: expected %0d, actual %0d", w.code, code);
                errors++;
            end
            if (last_flag !== w.last_flag)
            begin
                $error("last_char mismatch: expected %0d, actual %0d", w.last_flag,
                       last_flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [ValueW-1:0] value     = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CharW-1:0]  char_code;
    logic              last_char;

    text_scoreboard    sb = new();
    logic [ValueW-1:0] values_q[$];
    int                idle_pct = IdlePct;

    signed_decimal_to_ascii_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    always #10 clk = ~clk;

    // Fill the stimulus list: corner values first, then random words.
    task automatic build_values();
        int mag;
        values_q = '{16'sd0, 16'sd1, -16'sd1, 16'sd9, -16'sd9, 16'sd10, -16'sd10,
                     16'sd99, 16'sd100, -16'sd100, 16'sd999, 16'sd1000, 16'sd9999,
                     16'sd10000, -16'sd10000, 16'sd12345, -16'sd12345,
                     16'sd32767, -16'sd32767, 16'h8000};
        for (int i = 0; i < RandomItems; i++)
        begin
            // Mix full-range words with short magnitudes to vary the digit count.
            case ($urandom_range(3))
                0: mag = $urandom_range(9);
                1: mag = $urandom_range(999);
                2: mag = $urandom_range(32767);
                default: mag = -1;
            endcase
            if (mag < 0)
                values_q.push_back(ValueW'($urandom_range(65535)));
            else if ($urandom_range(1))
                values_q.push_back(ValueW'(-mag));
            else
                values_q.push_back(ValueW'(mag));
        end
    endtask

    // Offer the words in order; a new word is driven only after the last one is taken.
    task automatic send_values();
        int idx;
        bit taken;
        idx = 0;
        while (idx < values_q.size())
        begin
            @(posedge clk);
            taken = in_valid && !in_stall;
            if (taken)
            begin
                sb.note_value(value);
                idx++;
            end
            if (!in_valid || taken)
            begin
                idle_pct = (idx >= QuietFirst && idx < QuietLast) ? 0 : IdlePct;
                if (idx < values_q.size() && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    value    <= values_q[idx];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    endtask

    // Receiver: checks every taken character and stalls at random.
    // Once, it holds off for a long stretch so the core backs up into its input.
    initial
    begin
        int chars_taken;
        int hold_left;
        bit held;
        chars_taken = 0;
        hold_left   = 0;
        held        = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_char(char_code, last_char);
                chars_taken++;
            end
            if (!held && chars_taken >= HoldAfter)
            begin
                held = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n);
        while (quiet_cycles < WatchdogLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence: reset, stimulus, drain, verdict.
    initial
    begin
        build_values();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_values();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sdta_pkg.sv
hw/rtl/sdta_front.sv
hw/rtl/sdta_queue.sv
hw/rtl/sdta_back.sv
hw/rtl/signed_decimal_to_ascii_core.sv
tb/signed_decimal_to_ascii_core_tb.sv
